/* rtl/core/sequence_range_reduce_table_macros.svh */
// assertion macros for the sequence range reduce table
// used by the top level only; expects clk and arst_n in scope
`ifndef SEQUENCE_RANGE_REDUCE_TABLE_MACROS_SVH
`define SEQUENCE_RANGE_REDUCE_TABLE_MACROS_SVH

// same-cycle implication
`define SRRT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SRRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/srrt_pkg.sv */
// shared constants for the sequence range reduce table
// no dependencies
`default_nettype none
package srrt_pkg;
	localparam int DATA_W = 32;
	localparam int MOD_W  = 31;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_ERASE  = 3'd1;
	localparam logic [2:0] OP_CHANGE = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_REDUCE = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic CFG_MODE    = 1'b0;
	localparam logic CFG_MODULUS = 1'b1;

	typedef logic [DATA_W-1:0] word_t;
endpackage
`default_nettype wire

/* rtl/core/srrt_cell.sv */
// one storage cell of the rotating element chain
// depends on srrt_pkg
`default_nettype none
module srrt_cell (
	input  wire                  clk,
	input  wire                  shift,
	input  wire srrt_pkg::word_t d,
	output srrt_pkg::word_t      q
);
	import srrt_pkg::*;

	word_t val_q;

	// takes the neighbor's value on every shift step
	always_ff @(posedge clk) begin
		if (shift) begin
			val_q <= d;
		end
	end

	assign q = val_q;
endmodule
`default_nettype wire

/* rtl/core/srrt_modred.sv */
// bit-serial signed modulo unit: sign and magnitude in, residue in 0..m-1 out
// depends on srrt_pkg
`default_nettype none
module srrt_modred #(
	parameter int SUMW = 42
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire                        neg,
	input  wire [SUMW-1:0]             mag,
	input  wire [srrt_pkg::MOD_W-1:0]  modulus,
	output logic                       done,
	output logic [srrt_pkg::MOD_W-1:0] result
);
	import srrt_pkg::*;

	localparam int BW = $clog2(SUMW);

	logic            busy_q;
	logic [BW-1:0]   bit_q;
	logic [SUMW-1:0] mag_q;
	logic            neg_q;
	logic [MOD_W-1:0] m_q;
	logic [MOD_W-1:0] rem_q;
	logic [MOD_W:0]   trial;
	logic [MOD_W:0]   diff;
	logic [MOD_W-1:0] rem_nx;
	logic             last;

	assign trial  = {rem_q, mag_q[SUMW-1]};
	assign diff   = trial - {1'b0, m_q};
	assign rem_nx = diff[MOD_W] ? trial[MOD_W-1:0] : diff[MOD_W-1:0];
	assign last   = (bit_q == BW'(SUMW-1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			bit_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
			end else if (busy_q) begin
				bit_q <= bit_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
			neg_q <= neg;
			rem_q <= '0;
			// modulus zero behaves as one
			m_q   <= (modulus == '0) ? MOD_W'(1) : modulus;
		end else if (busy_q) begin
			mag_q <= {mag_q[SUMW-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

	assign result = (neg_q && rem_q != '0) ? (m_q - rem_q) : rem_q;
endmodule
`default_nettype wire

/* rtl/core/sequence_range_reduce_table.sv */
// ordered table of signed words with insert, erase, change, read, range reduce
// every accepted op makes one full rotation of the CAPACITY-cell chain before the response;
// a sum reduce then also runs the bit-serial modulo unit before the response is registered
// rejected and unknown requests skip the rotation and respond directly; one request at a time
// reset clears the count and control state and sets the modulus to one; cell contents stay undefined until written
`default_nettype none
module sequence_range_reduce_table #(
	parameter int CAPACITY = 1024
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [0:0]                    cfg_index,
	input  wire  [srrt_pkg::MOD_W-1:0]    cfg_data,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [2:0]                    opcode,
	input  wire  [$clog2(CAPACITY+1)-1:0] position,
	input  wire  [$clog2(CAPACITY)-1:0]   right_position,
	input  wire  signed [srrt_pkg::DATA_W-1:0] new_value,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic signed [srrt_pkg::DATA_W-1:0] read_data,
	output logic [$clog2(CAPACITY+1)-1:0] element_count,
	output logic [1:0]                    status
);
	import srrt_pkg::*;
	`include "sequence_range_reduce_table_macros.svh"

	localparam int KW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY+1);
	localparam int SUMW  = DATA_W + KW;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SWEEP = 3'd1;
	localparam logic [2:0] S_PRE   = 3'd2;
	localparam logic [2:0] S_MOD   = 3'd3;
	localparam logic [2:0] S_WAIT  = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic             mode_q;
	logic [MOD_W-1:0] modulus_q;
	logic [2:0]       op_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] rpos_q;
	word_t            val_q;
	logic [KW-1:0]    k_q;
	word_t            prev_q;
	logic signed [SUMW-1:0] sum_q;
	word_t            xor_q;
	word_t            res_data_q;
	logic [1:0]       res_status_q;
	logic             out_valid_q;
	word_t            read_data_q;
	logic [CNT_W-1:0] count_out_q;
	logic [1:0]       status_out_q;

	word_t            cq [CAPACITY];
	word_t            feed;
	logic             shift;
	logic [CNT_W-1:0] kx;
	logic             last_step;
	logic             in_range;
	logic             acc_go;
	logic [1:0]       acc_status;
	logic [CNT_W-1:0] rpos_x;
	logic             mr_start;
	logic             mr_done;
	logic [MOD_W-1:0] mr_result;
	logic [SUMW-1:0]  sum_mag;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign shift     = (state_q == S_SWEEP);
	assign kx        = CNT_W'(k_q);
	assign last_step = (k_q == KW'(CAPACITY-1));
	assign rpos_x    = CNT_W'(right_position);
	assign in_range  = (kx >= pos_q) && (kx <= rpos_q);

	// check the request against the current count
	always_comb begin
		acc_go     = 1'b0;
		acc_status = ST_OK;
		case (opcode)
			OP_INSERT: begin
				if (position > count_q) acc_status = ST_RANGE;
				else if (count_q == CNT_W'(CAPACITY)) acc_status = ST_FULL;
				else acc_go = 1'b1;
			end
			OP_ERASE, OP_CHANGE, OP_READ: begin
				if (position >= count_q) acc_status = ST_RANGE;
				else acc_go = 1'b1;
			end
			OP_REDUCE: begin
				if (position > rpos_x || rpos_x >= count_q) acc_status = ST_RANGE;
				else acc_go = 1'b1;
			end
			default: acc_go = 1'b0;
		endcase
	end

	// value fed into the tail of the chain lands at logical index k
	always_comb begin
		case (op_q)
			OP_INSERT: feed = (kx < pos_q) ? cq[0] : ((kx == pos_q) ? val_q : prev_q);
			OP_ERASE:  feed = (kx < pos_q) ? cq[0] : cq[1];
			OP_CHANGE: feed = (kx == pos_q) ? val_q : cq[0];
			default:   feed = cq[0];
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		srrt_cell u_cell (
			.clk   (clk),
			.shift (shift),
			.d     ((i == CAPACITY-1) ? feed : cq[(i+1) % CAPACITY]),
			.q     (cq[i])
		);
	end

	assign sum_mag  = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
	assign mr_start = (state_q == S_PRE) && (op_q == OP_REDUCE) && !mode_q;

	srrt_modred #(.SUMW(SUMW)) u_modred (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mr_start),
		.neg     (sum_q[SUMW-1]),
		.mag     (sum_mag),
		.modulus (modulus_q),
		.done    (mr_done),
		.result  (mr_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			mode_q      <= 1'b0;
			modulus_q   <= MOD_W'(1);
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_MODE) mode_q <= cfg_data[0];
				else modulus_q <= cfg_data;
			end
			if (out_valid_q && out_ready && state_q != S_WAIT) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						k_q     <= '0;
						state_q <= acc_go ? S_SWEEP : S_WAIT;
					end
				end
				S_SWEEP: begin
					k_q <= k_q + 1'b1;
					if (last_step) begin
						if (op_q == OP_INSERT) count_q <= count_q + 1'b1;
						if (op_q == OP_ERASE) count_q <= count_q - 1'b1;
						state_q <= S_PRE;
					end
				end
				S_PRE: begin
					state_q <= mr_start ? S_MOD : S_WAIT;
				end
				S_MOD: begin
					if (mr_done) state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q         <= opcode;
				pos_q        <= position;
				rpos_q       <= rpos_x;
				val_q        <= new_value;
				res_data_q   <= '0;
				res_status_q <= acc_status;
				sum_q        <= '0;
				xor_q        <= '0;
			end
			S_SWEEP: begin
				prev_q <= cq[0];
				if (op_q == OP_READ && kx == pos_q) res_data_q <= cq[0];
				if (op_q == OP_REDUCE && in_range) begin
					sum_q <= sum_q + SUMW'(signed'(cq[0]));
					xor_q <= xor_q ^ cq[0];
				end
			end
			S_PRE: begin
				if (op_q == OP_REDUCE && mode_q) res_data_q <= xor_q;
			end
			S_MOD: begin
				if (mr_done) res_data_q <= DATA_W'(mr_result);
			end
			S_WAIT: begin
				if (!out_valid_q || out_ready) begin
					read_data_q  <= res_data_q;
					count_out_q  <= count_q;
					status_out_q <= res_status_q;
				end
			end
			default: begin
				prev_q <= prev_q;
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign read_data     = signed'(read_data_q);
	assign element_count = count_out_q;
	assign status        = status_out_q;

	`SRRT_ASSERT_NOW(a_count_cap, 1'b1, count_q <= CNT_W'(CAPACITY), "count beyond capacity")
	`SRRT_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_q != S_IDLE, "request not taken")
	`SRRT_ASSERT_NOW(a_done_in_mod, mr_done, state_q == S_MOD, "modulo done outside mod state")
	`SRRT_ASSERT_NOW(a_status_code, out_valid, status != 2'd3, "bad status code")
endmodule
`default_nettype wire

/* tb/sv/srrt_checker.sv */
// result checker for the sequence range reduce table
// tracks register writes and requests, predicts each response and compares it
// depends on srrt_pkg
`default_nettype none
module srrt_checker (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_valid,
	input  wire                       cfg_ready,
	input  wire  [0:0]                cfg_index,
	input  wire  [srrt_pkg::MOD_W-1:0] cfg_data,
	input  wire                       in_valid,
	input  wire                       in_ready,
	input  wire  [2:0]                opcode,
	input  wire  [10:0]               position,
	input  wire  [9:0]                right_position,
	input  wire  signed [31:0]        new_value,
	input  wire                       out_valid,
	input  wire                       out_ready,
	input  wire  signed [31:0]        read_data,
	input  wire  [10:0]               element_count,
	input  wire  [1:0]                status,
	output int                        fail_count,
	output int                        pending
);
	import srrt_pkg::*;

	localparam int DEPTH = 1024;
	localparam int EXP_DEPTH = 8;

	typedef struct {
		logic [31:0] data;
		logic [10:0] count;
		logic [1:0]  stat;
	} table_result_t;

	logic [31:0]          seq_words [DEPTH];
	int                   seq_len;
	logic                 xor_mode;
	logic [MOD_W-1:0]     sum_modulus;
	table_result_t        exp_fifo [EXP_DEPTH];
	int                   exp_wr;
	int                   exp_rd;
	int                   exp_fill;

	function automatic logic [31:0] range_reduce(int lo, int hi);
		longint m;
		longint acc;
		longint v;
		longint r;
		logic [31:0] x;
		x = '0;
		acc = 0;
		m = (sum_modulus == 0) ? 1 : longint'(sum_modulus);
		for (int i = lo; i <= hi; i++) begin
			if (xor_mode) begin
				x ^= seq_words[i];
			end else begin
				v = longint'($signed(seq_words[i]));
				r = v % m;
				if (r < 0)
					r += m;
				acc = (acc + r) % m;
			end
		end
		return xor_mode ? x : acc[31:0];
	endfunction

	function automatic table_result_t apply_table_op(logic [2:0] op, int pos, int rpos,
			logic [31:0] val);
		table_result_t res;
		res.data = '0;
		res.stat = ST_OK;
		case (op)
			OP_INSERT: begin
				if (pos > seq_len) begin
					res.stat = ST_RANGE;
				end else if (seq_len >= DEPTH) begin
					res.stat = ST_FULL;
				end else begin
					for (int i = seq_len; i > pos; i--)
						seq_words[i] = seq_words[i-1];
					seq_words[pos] = val;
					seq_len++;
				end
			end
			OP_ERASE: begin
				if (pos >= seq_len) begin
					res.stat = ST_RANGE;
				end else begin
					for (int i = pos; i + 1 < seq_len; i++)
						seq_words[i] = seq_words[i+1];
					seq_len--;
				end
			end
			OP_CHANGE: begin
				if (pos >= seq_len)
					res.stat = ST_RANGE;
				else
					seq_words[pos] = val;
			end
			OP_READ: begin
				if (pos >= seq_len)
					res.stat = ST_RANGE;
				else
					res.data = seq_words[pos];
			end
			OP_REDUCE: begin
				if (pos > rpos || rpos >= seq_len)
					res.stat = ST_RANGE;
				else
					res.data = range_reduce(pos, rpos);
			end
			default: ;
		endcase
		res.count = seq_len[10:0];
		return res;
	endfunction

	assign pending = exp_fill;

	always @(posedge clk or negedge arst_n) begin
		table_result_t exp_res;
		if (!arst_n) begin
			seq_len = 0;
			xor_mode = 1'b0;
			sum_modulus = 1;
			fail_count = 0;
			exp_wr = 0;
			exp_rd = 0;
			exp_fill = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MODE)
					xor_mode = cfg_data[0];
				else
					sum_modulus = cfg_data;
			end
			if (in_valid && in_ready) begin
				if (exp_fill >= EXP_DEPTH) begin
					$error("too many requests outstanding");
					fail_count++;
				end else begin
					exp_fifo[exp_wr] = apply_table_op(opcode, int'(position),
						int'(right_position), new_value);
					exp_wr = (exp_wr + 1) % EXP_DEPTH;
					exp_fill++;
				end
			end
			if (out_valid && out_ready) begin
				if (exp_fill == 0) begin
					$error("response with no request outstanding");
					fail_count++;
				end else begin
					exp_res = exp_fifo[exp_rd];
					exp_rd = (exp_rd + 1) % EXP_DEPTH;
					exp_fill--;
					if (read_data !== exp_res.data) begin
						$error("read_data expected %0h actual %0h", exp_res.data, read_data);
						fail_count++;
					end
					if (element_count !== exp_res.count) begin
						$error("element_count expected %0d actual %0d", exp_res.count,
							element_count);
						fail_count++;
					end
					if (status !== exp_res.stat) begin
						$error("status expected %0d actual %0d", exp_res.stat, status);
						fail_count++;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

/* tb/sv/tb_sequence_range_reduce_table.sv */
// top testbench for the sequence range reduce table
// drives requests, register writes and response backpressure; srrt_checker judges
// depends on srrt_pkg, sequence_range_reduce_table and srrt_checker
`default_nettype none
module tb_sequence_range_reduce_table;
	import srrt_pkg::*;

	localparam int DEPTH = 1024;
	localparam int IDLE_LIMIT = 20000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [0:0]          cfg_index = '0;
	logic [MOD_W-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [2:0]          opcode = '0;
	logic [10:0]         position = '0;
	logic [9:0]          right_position = '0;
	logic signed [31:0]  new_value = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic signed [31:0]  read_data;
	logic [10:0]         element_count;
	logic [1:0]          status;
	int                  fail_count;
	int                  pending;

	int   shadow_len = 0;
	int   sent = 0;
	int   full_hits = 0;
	int   idle_cycles = 0;
	int   ready_wait = 0;
	bit   no_gaps = 0;

	always #1 clk = ~clk;

	sequence_range_reduce_table u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .position(position),
		.right_position(right_position), .new_value(new_value),
		.out_valid(out_valid), .out_ready(out_ready), .read_data(read_data),
		.element_count(element_count), .status(status)
	);

	srrt_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .position(position),
		.right_position(right_position), .new_value(new_value),
		.out_valid(out_valid), .out_ready(out_ready), .read_data(read_data),
		.element_count(element_count), .status(status),
		.fail_count(fail_count), .pending(pending)
	);

	// response side backpressure: a fresh stall length after every response
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			ready_wait = no_gaps ? 0 : $urandom_range(0, 5);
			out_ready <= (ready_wait == 0);
		end else if (ready_wait > 0) begin
			ready_wait--;
			out_ready <= (ready_wait == 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_request(logic [2:0] op, logic [10:0] pos, logic [9:0] rpos,
			logic [31:0] val);
		int gap;
		opcode <= op;
		position <= pos;
		right_position <= rpos;
		new_value <= val;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sent++;
		// keep a rough count to steer positions toward legal ones
		if (op == OP_INSERT && pos <= shadow_len) begin
			if (shadow_len < DEPTH)
				shadow_len++;
			else
				full_hits++;
		end else if (op == OP_ERASE && pos < shadow_len) begin
			shadow_len--;
		end
		gap = no_gaps ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_responses();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [MOD_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_request(int insert_pct);
		int roll;
		logic [2:0] op;
		logic [10:0] pos;
		logic [9:0] rpos;
		roll = $urandom_range(0, 99);
		if (roll < insert_pct)
			op = OP_INSERT;
		else if (roll < insert_pct + (100 - insert_pct) / 4)
			op = OP_ERASE;
		else if (roll < 97)
			op = 3'($urandom_range(OP_CHANGE, OP_REDUCE));
		else
			op = 3'($urandom_range(5, 7));
		if ($urandom_range(0, 9) == 0) begin
			pos = 11'($urandom);
			rpos = 10'($urandom);
		end else if (op == OP_INSERT) begin
			pos = 11'($urandom_range(0, shadow_len));
			rpos = 10'($urandom);
		end else begin
			pos = 11'($urandom_range(0, shadow_len > 0 ? shadow_len - 1 : 0));
			rpos = 10'($urandom_range(int'(pos) < DEPTH ? int'(pos) : 0,
				shadow_len > 0 ? shadow_len - 1 : 0));
		end
		send_request(op, pos, rpos, $urandom);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store, illegal positions, value extremes, unknown opcodes
		send_request(OP_READ, 0, 0, 0);
		send_request(OP_REDUCE, 0, 0, 0);
		send_request(OP_ERASE, 0, 0, 0);
		send_request(OP_CHANGE, 0, 0, 32'h1234);
		send_request(OP_INSERT, 1, 0, 32'h5);
		send_request(OP_INSERT, 0, 0, 32'h8000_0000);
		send_request(OP_INSERT, 1, 0, 32'h7fff_ffff);
		send_request(OP_INSERT, 0, 0, 32'hffff_ffff);
		send_request(OP_INSERT, 3, 10'h3ff, 32'h0);
		send_request(OP_INSERT, 11'h7ff, 0, 32'h1);
		send_request(OP_READ, 0, 0, 0);
		send_request(OP_READ, 4, 0, 0);
		send_request(OP_CHANGE, 2, 0, 32'h0000_00ff);
		send_request(OP_REDUCE, 0, 3, 0);
		send_request(OP_REDUCE, 2, 1, 0);
		send_request(OP_REDUCE, 1, 10'h3ff, 0);
		send_request(3'd5, 11'h7ff, 10'h3ff, 32'hffff_ffff);
		send_request(3'd6, 0, 0, 0);
		send_request(3'd7, 1, 1, 1);
		send_request(OP_ERASE, 0, 0, 0);
		send_request(OP_ERASE, 11'h400, 0, 0);
		drain_responses();

		// phase 1 fills the store past capacity; later phases mix all operations
		for (int ph = 1; ph <= 5; ph++) begin
			case (ph)
				1: begin
					write_reg(CFG_MODE, 0);
					write_reg(CFG_MODULUS, 31'h7fff_ffff);
				end
				2: write_reg(CFG_MODE, 1);
				3: begin
					write_reg(CFG_MODE, 0);
					write_reg(CFG_MODULUS, 0);
				end
				4: write_reg(CFG_MODULUS, 31'($urandom_range(2, 1000)));
				default: begin
					write_reg(CFG_MODE, 1);
					write_reg(CFG_MODULUS, 31'($urandom));
				end
			endcase
			no_gaps = (ph == 3);
			for (int n = 0; n < (ph == 1 ? 1200 : 150); n++) begin
				random_request(ph == 1 ? 95 : 30);
				if (ph == 1 && shadow_len == DEPTH && full_hits > 20)
					break;
			end
			drain_responses();
		end

		$display("ran %0d requests over six register settings", sent);
		$display("store seen full on %0d insert attempts", full_hits);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
`default_nettype wire
